>>> hdl/type_length_packet_deframer_unit_defines.svh
// Assertion macros for the type-length packet deframer.
// Included by the top level; depends on nothing else.
`ifndef TYPE_LENGTH_PACKET_DEFRAMER_UNIT_DEFINES_SVH
`define TYPE_LENGTH_PACKET_DEFRAMER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define TLPD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tlpd check failed");

// Next-cycle implication, checked outside reset
`define TLPD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tlpd check failed");

`endif

>>> hdl/tlpd_pkg.sv
// Shared types and constants of the type-length packet deframer.
// Used by the front parser, the result queue, the output stage and the top level.
package tlpd_pkg;

  // Defaults for the top-level parameters
  localparam int LENGTH_BITS_DEF = 24;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Configuration port
  localparam int CFG_INDEX_BITS = 4;
  localparam int CODE_BITS      = 8;

  localparam logic [CFG_INDEX_BITS-1:0] REG_HANDSHAKE = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_HEARTBEAT = CFG_INDEX_BITS'(1);
  localparam logic [CFG_INDEX_BITS-1:0] REG_DATA      = CFG_INDEX_BITS'(2);
  localparam logic [CFG_INDEX_BITS-1:0] REG_KICK      = CFG_INDEX_BITS'(3);

  localparam logic [CODE_BITS-1:0] HANDSHAKE_RST = 8'd1;
  localparam logic [CODE_BITS-1:0] HEARTBEAT_RST = 8'd3;
  localparam logic [CODE_BITS-1:0] DATA_RST      = 8'd4;
  localparam logic [CODE_BITS-1:0] KICK_RST      = 8'd5;

  // Packet kinds as reported on the result channel
  localparam logic [1:0] KIND_HANDSHAKE = 2'd0;
  localparam logic [1:0] KIND_HEARTBEAT = 2'd1;
  localparam logic [1:0] KIND_DATA      = 2'd2;
  localparam logic [1:0] KIND_KICK      = 2'd3;

  // Front parser states
  typedef enum logic [1:0] {
    ST_TYPE,
    ST_LENGTH,
    ST_PAYLOAD,
    ST_STUCK
  } front_state_t;

  // One result item
  typedef struct packed {
    logic [1:0] packet_kind;
    logic [7:0] payload_byte;
    logic       has_byte;
    logic       end_of_packet;
    logic       bad_type;
  } result_t;

  // Front to queue: a result and its write strobe
  typedef struct packed {
    logic    valid;
    result_t res;
  } push_t;

endpackage

>>> hdl/tlpd_front.sv
// Front parser: accepts stream bytes, tracks the header and payload, emits results.
// Holds the type-code registers. Depends on tlpd_pkg.
module tlpd_front #(
  parameter int LENGTH_BITS = tlpd_pkg::LENGTH_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_stream_byte,
  input  logic                                cfg_we,
  input  logic [tlpd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [tlpd_pkg::CODE_BITS-1:0]      cfg_data,
  input  logic                                q_ready,
  output tlpd_pkg::push_t                     push,
  output logic                                stuck
);
  import tlpd_pkg::*;

  localparam int LEN_BYTES = (LENGTH_BITS + 7) / 8;
  localparam int CW        = $clog2(LEN_BYTES + 1);

  front_state_t            state_r, state_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [LENGTH_BITS-1:0]  rem_r, rem_nxt;
  logic [1:0]              kind_r, kind_nxt;
  logic [7:0]              type_r, type_nxt;
  logic [CODE_BITS-1:0]    hs_code_r, hb_code_r, dat_code_r, kick_code_r;

  logic                    accept;
  logic [LENGTH_BITS+7:0]  acc_wide;
  logic [LENGTH_BITS-1:0]  acc_len;
  logic                    len_last;
  logic                    pay_last;
  logic                    hit_hs, hit_dat, hit_hb, hit_kick;

  // Take a byte whenever the queue has room
  assign in_stall = !q_ready;
  assign accept   = in_valid && q_ready;
  assign stuck    = (state_r == ST_STUCK);

  // Shift the next length byte in, big-endian
  assign acc_wide = {rem_r, in_stream_byte};
  assign acc_len  = acc_wide[LENGTH_BITS-1:0];
  assign len_last = (cnt_r == CW'(LEN_BYTES - 1));
  assign pay_last = (rem_r <= LENGTH_BITS'(1));

  // Decode the held type byte
  assign hit_hs   = (type_r == hs_code_r);
  assign hit_dat  = (type_r == dat_code_r);
  assign hit_hb   = (type_r == hb_code_r);
  assign hit_kick = (type_r == kick_code_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_TYPE: begin
        if (accept) state_nxt = ST_LENGTH;
      end
      ST_LENGTH: begin
        if (accept && len_last) begin
          if (hit_hs || hit_dat) begin
            state_nxt = (acc_len == '0) ? ST_TYPE : ST_PAYLOAD;
          end else if (hit_hb || hit_kick) begin
            state_nxt = ST_TYPE;
          end else begin
            state_nxt = ST_STUCK;
          end
        end
      end
      ST_PAYLOAD: begin
        if (accept && pay_last) state_nxt = ST_TYPE;
      end
      ST_STUCK: state_nxt = ST_STUCK;
      default:  state_nxt = ST_TYPE;
    endcase
  end

  // Datapath updates and result generation
  always_comb begin
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    kind_nxt  = kind_r;
    type_nxt  = type_r;
    push      = '0;
    case (state_r)
      ST_TYPE: begin
        if (accept) begin
          type_nxt = in_stream_byte;
          rem_nxt  = '0;
          cnt_nxt  = '0;
        end
      end
      ST_LENGTH: begin
        if (accept) begin
          rem_nxt = acc_len;
          if (!len_last) begin
            cnt_nxt = cnt_r + CW'(1);
          end else if (hit_hs || hit_dat) begin
            kind_nxt = hit_hs ? KIND_HANDSHAKE : KIND_DATA;
            if (acc_len == '0) begin
              push.valid             = 1'b1;
              push.res.packet_kind   = hit_hs ? KIND_HANDSHAKE : KIND_DATA;
              push.res.end_of_packet = 1'b1;
            end
          end else begin
            rem_nxt    = '0;
            push.valid = 1'b1;
            if (hit_hb) begin
              push.res.packet_kind   = KIND_HEARTBEAT;
              push.res.end_of_packet = 1'b1;
            end else if (hit_kick) begin
              push.res.packet_kind   = KIND_KICK;
              push.res.end_of_packet = 1'b1;
            end else begin
              push.res.bad_type = 1'b1;
            end
          end
        end
      end
      ST_PAYLOAD: begin
        if (accept) begin
          push.valid             = 1'b1;
          push.res.packet_kind   = kind_r;
          push.res.payload_byte  = in_stream_byte;
          push.res.has_byte      = 1'b1;
          push.res.end_of_packet = pay_last;
          rem_nxt = pay_last ? '0 : (rem_r - LENGTH_BITS'(1));
        end
      end
      ST_STUCK: begin
        // drop everything until reset
      end
      default: begin
      end
    endcase
  end

  // Parser registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_TYPE;
      cnt_r   <= '0;
      rem_r   <= '0;
      kind_r  <= KIND_HANDSHAKE;
      type_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rem_r   <= rem_nxt;
      kind_r  <= kind_nxt;
      type_r  <= type_nxt;
    end
  end

  // Type-code registers; ignore writes beyond the list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hs_code_r   <= HANDSHAKE_RST;
      hb_code_r   <= HEARTBEAT_RST;
      dat_code_r  <= DATA_RST;
      kick_code_r <= KICK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HANDSHAKE: hs_code_r   <= cfg_data;
        REG_HEARTBEAT: hb_code_r   <= cfg_data;
        REG_DATA:      dat_code_r  <= cfg_data;
        REG_KICK:      kick_code_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

>>> hdl/tlpd_queue.sv
// Short result queue between the front parser and the output stage.
// Register-array FIFO of result_t entries. Depends on tlpd_pkg.
module tlpd_queue #(
  parameter int QUEUE_DEPTH = tlpd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tlpd_pkg::push_t   push,
  output logic              q_ready,
  output logic              q_valid,
  output tlpd_pkg::result_t q_data,
  input  logic              q_pop
);
  import tlpd_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  result_t         mem [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign q_ready = (count_r != NW'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_data  = mem[rd_ptr_r];
  assign do_push = push.valid && q_ready;
  assign do_pop  = q_pop && q_valid;

  // Advance pointers with wrap and track fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + NW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed result
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push.res;
  end

endmodule

>>> hdl/tlpd_back.sv
// Output stage: registers one result and presents it on the result channel.
// Pulls from the result queue. Depends on tlpd_pkg.
module tlpd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  tlpd_pkg::result_t q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output tlpd_pkg::result_t out_res
);
  import tlpd_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;
  logic    load;

  // Load when the register is empty or its item leaves this cycle
  assign load      = q_valid && (!valid_r || !out_stall);
  assign q_pop     = load;
  assign valid_nxt = load ? 1'b1 : (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold the payload while stalled
  always_ff @(posedge clk) begin
    if (load) res_r <= q_data;
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

>>> hdl/type_length_packet_deframer_unit.sv
// Type-length packet deframer, top level.
// Input channel: one stream byte per item (in_valid / in_stall / in_stream_byte).
// Result channel: out_valid / out_stall with kind, payload byte, has_byte,
// end_of_packet and bad_type. A packet is a type byte, then a big-endian
// length of LENGTH_BITS bits; handshake and data packets give one result per
// payload byte (one end-of-packet result if length is 0), heartbeat and kick one
// at header end, an unknown type one error result; then all bytes drop until reset.
// Config port: cfg_valid / cfg_ready / cfg_index / cfg_data writes the four
// type codes (handshake, heartbeat, data, kick); cfg_ready is always high.
// Throughput: one byte per cycle, sustained while the queue has room (in_stall low).
// Path: the result of an accepted byte is written into the queue, then loaded
// into the output register, which drives out_valid.
// Stall: out_stall holds the output register; the queue behind it fills, and
// in_stall rises once the QUEUE_DEPTH entries are taken.
// Reset (rst_n low, synchronous): parser waits for a type byte, codes return to
// 1, 3, 4, 5, queue and output register are emptied.
// Depends on tlpd_pkg, tlpd_front, tlpd_queue, tlpd_back and the defines header.
`include "type_length_packet_deframer_unit_defines.svh"

module type_length_packet_deframer_unit #(
  parameter int LENGTH_BITS = tlpd_pkg::LENGTH_BITS_DEF,
  parameter int QUEUE_DEPTH = tlpd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_stream_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          out_packet_kind,
  output logic [7:0]                          out_payload_byte,
  output logic                                out_has_byte,
  output logic                                out_end_of_packet,
  output logic                                out_bad_type,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tlpd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [tlpd_pkg::CODE_BITS-1:0]      cfg_data
);
  import tlpd_pkg::*;

  push_t   fr_push;
  logic    fr_stuck;
  logic    q_ready, q_valid, q_pop;
  result_t q_data;
  result_t out_res;

  assign cfg_ready = 1'b1;

  // Parse the byte stream
  tlpd_front #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_stream_byte (in_stream_byte),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .q_ready        (q_ready),
    .push           (fr_push),
    .stuck          (fr_stuck)
  );

  // Buffer results between parser and output
  tlpd_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (fr_push),
    .q_ready (q_ready),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop)
  );

  // Present results
  tlpd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_packet_kind   = out_res.packet_kind;
  assign out_payload_byte  = out_res.payload_byte;
  assign out_has_byte      = out_res.has_byte;
  assign out_end_of_packet = out_res.end_of_packet;
  assign out_bad_type      = out_res.bad_type;

  // The parser never writes into a full queue
  `TLPD_ASSERT_IMP(a_push_has_room, clk, rst_n, fr_push.valid, q_ready)
  // The error state is kept until reset
  `TLPD_ASSERT_NXT(a_stuck_holds, clk, rst_n, fr_stuck, fr_stuck)
  // Entering the error state follows an error result
  `TLPD_ASSERT_IMP(a_stuck_after_bad, clk, rst_n, $rose(fr_stuck), $past(fr_push.valid && fr_push.res.bad_type))
  // An error result carries no byte and closes no packet
  `TLPD_ASSERT_IMP(a_bad_is_bare, clk, rst_n, out_valid && out_bad_type, !out_has_byte && !out_end_of_packet)

endmodule
